### src/adl_pkg.sv
`default_nettype none

package adl_pkg;

  localparam int DATA_W = 24;
  localparam int SIZE_W = 6;
  localparam int COORD_W = 5;
  localparam int NB_W = 6;
  localparam int FLUX_W = 37;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW = $clog2(QUEUE_DEPTH);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LONG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TRANS = 3'd4;

  // order in which the seven stencil taps are read
  localparam logic [2:0] TAP_CENTRE = 3'd0;
  localparam logic [2:0] TAP_XL = 3'd1;
  localparam logic [2:0] TAP_XU = 3'd2;
  localparam logic [2:0] TAP_YL = 3'd3;
  localparam logic [2:0] TAP_YU = 3'd4;
  localparam logic [2:0] TAP_ZL = 3'd5;
  localparam logic [2:0] TAP_ZU = 3'd6;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_BAD   = 2'd2
  } kind_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [DATA_W-1:0]  conc_value;
  } item_t;

  typedef struct packed {
    logic signed [FLUX_W-1:0] flux;
    logic                     bad_coord;
  } result_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [NB_W-1:0]    xl;
    logic [NB_W-1:0]    xu;
    logic [NB_W-1:0]    yl;
    logic [NB_W-1:0]    yu;
    logic [NB_W-1:0]    zl;
    logic [NB_W-1:0]    zu;
    logic [DATA_W-1:0]  value;
  } entry_t;

endpackage

`default_nettype wire

### src/adl_front.sv
`default_nettype none

module adl_front #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  wire adl_pkg::item_t                 item,
  input  wire                                 start,
  input  wire                                 full,
  input  wire logic [adl_pkg::SIZE_W-1:0]     size_x,
  input  wire logic [adl_pkg::SIZE_W-1:0]     size_y,
  input  wire logic [adl_pkg::SIZE_W-1:0]     size_z,
  output logic                                push,
  output adl_pkg::entry_t                     entry
);

  localparam logic [8:0] MaxXv = 9'(MAX_X);
  localparam logic [8:0] MaxYv = 9'(MAX_Y);
  localparam logic [8:0] MaxZv = 9'(MAX_Z);

  // sizes below two act as two, sizes past the grid act as the grid
  function automatic logic [8:0] use_size(input logic [adl_pkg::SIZE_W-1:0] sz,
                                          input logic [8:0] maxv);
    logic [8:0] s;
    s = 9'(sz);
    if (s < 9'd2) begin
      return 9'd2;
    end else if (s > maxv) begin
      return maxv;
    end
    return s;
  endfunction

  function automatic logic [adl_pkg::NB_W-1:0] lower_nb(input logic [adl_pkg::COORD_W-1:0] c);
    return (c == '0) ? adl_pkg::NB_W'(1) : adl_pkg::NB_W'(c) - adl_pkg::NB_W'(1);
  endfunction

  // reflect at the upper face
  function automatic logic [adl_pkg::NB_W-1:0] upper_nb(input logic [adl_pkg::COORD_W-1:0] c,
                                                        input logic [8:0] n);
    return (9'(c) + 9'd1 >= n) ? adl_pkg::NB_W'(c) - adl_pkg::NB_W'(1)
                               : adl_pkg::NB_W'(c) + adl_pkg::NB_W'(1);
  endfunction

  logic [8:0] nx, ny, nz;
  logic       in_grid;
  logic       in_use;

  always_comb begin
    nx = use_size(size_x, MaxXv);
    ny = use_size(size_y, MaxYv);
    nz = use_size(size_z, MaxZv);
    in_grid = (9'(item.cell_x) < MaxXv) && (9'(item.cell_y) < MaxYv)
              && (9'(item.cell_z) < MaxZv);
    in_use = (9'(item.cell_x) < nx) && (9'(item.cell_y) < ny) && (9'(item.cell_z) < nz);

    entry.x = item.cell_x;
    entry.y = item.cell_y;
    entry.z = item.cell_z;
    entry.xl = lower_nb(item.cell_x);
    entry.xu = upper_nb(item.cell_x, nx);
    entry.yl = lower_nb(item.cell_y);
    entry.yu = upper_nb(item.cell_y, ny);
    entry.zl = lower_nb(item.cell_z);
    entry.zu = upper_nb(item.cell_z, nz);
    entry.value = item.conc_value;

    if (item.func == adl_pkg::FUNC_WRITE) begin
      entry.kind = adl_pkg::KIND_WRITE;
    end else if (in_use) begin
      entry.kind = adl_pkg::KIND_QUERY;
    end else begin
      entry.kind = adl_pkg::KIND_BAD;
    end

    // writes beyond the grid are dropped here
    push = start && !full && ((item.func == adl_pkg::FUNC_QUERY) || in_grid);
  end

endmodule

`default_nettype wire

### src/adl_queue.sv
`default_nettype none

module adl_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  wire adl_pkg::entry_t   push_entry,
  input  wire                    pop,
  output adl_pkg::entry_t        head,
  output logic                   empty,
  output logic                   full
);

  adl_pkg::entry_t             slots [adl_pkg::QUEUE_DEPTH];
  logic [adl_pkg::QAW-1:0]     wr_ptr;
  logic [adl_pkg::QAW-1:0]     rd_ptr;
  logic [adl_pkg::QAW:0]       count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (adl_pkg::QAW+1)'(adl_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == adl_pkg::QAW'(adl_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + adl_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == adl_pkg::QAW'(adl_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + adl_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (adl_pkg::QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (adl_pkg::QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/adl_back.sv
`default_nettype none

module adl_back #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire adl_pkg::entry_t              head,
  input  wire                               empty,
  output logic                              pop,
  input  wire logic [adl_pkg::DATA_W-1:0]   coef_long,
  input  wire logic [adl_pkg::DATA_W-1:0]   coef_trans,
  output logic                              result_valid,
  output adl_pkg::result_t                  result
);

  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW = $clog2(CELLS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_DIFF  = 6'b001000,
    S_MUL   = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [adl_pkg::NB_W-1:0] cx,
                                              input logic [adl_pkg::NB_W-1:0] cy,
                                              input logic [adl_pkg::NB_W-1:0] cz);
    logic [31:0] lin;
    lin = 32'(cx) + 32'(MAX_X) * (32'(cy) + 32'(MAX_Y) * 32'(cz));
    return AW'(lin);
  endfunction

  logic [adl_pkg::DATA_W-1:0] mem [CELLS];

  state_t                      state;
  adl_pkg::entry_t             cur;
  logic [2:0]                  step;
  logic                        rd_live;
  logic [2:0]                  rd_step;
  logic [adl_pkg::DATA_W-1:0]  rdata;
  logic [adl_pkg::DATA_W-1:0]  centre;
  logic [adl_pkg::DATA_W:0]    sum_x, sum_y, sum_z;
  logic signed [25:0]          dx, dy, dz;
  logic signed [50:0]          px, py, pz;
  logic signed [34:0]          fx, fy, fz;

  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [adl_pkg::NB_W-1:0]    tap_x, tap_y, tap_z;

  assign pop    = (state == S_IDLE) && !empty;
  assign mem_we = pop && (head.kind == adl_pkg::KIND_WRITE);

  always_comb begin
    tap_x = {1'b0, cur.x};
    tap_y = {1'b0, cur.y};
    tap_z = {1'b0, cur.z};
    case (step)
      adl_pkg::TAP_XL: tap_x = cur.xl;
      adl_pkg::TAP_XU: tap_x = cur.xu;
      adl_pkg::TAP_YL: tap_y = cur.yl;
      adl_pkg::TAP_YU: tap_y = cur.yu;
      adl_pkg::TAP_ZL: tap_z = cur.zl;
      adl_pkg::TAP_ZU: tap_z = cur.zu;
      default: ;
    endcase
    if (state == S_IDLE) begin
      mem_addr = cell_addr({1'b0, head.x}, {1'b0, head.y}, {1'b0, head.z});
    end else begin
      mem_addr = cell_addr(tap_x, tap_y, tap_z);
    end
  end

  // single-port grid store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= head.value;
    end
    rdata <= mem[mem_addr];
  end

  // tap accumulation
  always_ff @(posedge clk) begin
    if (rd_live) begin
      case (rd_step)
        adl_pkg::TAP_CENTRE: centre <= rdata;
        adl_pkg::TAP_XL:     sum_x <= {1'b0, rdata};
        adl_pkg::TAP_XU:     sum_x <= sum_x + {1'b0, rdata};
        adl_pkg::TAP_YL:     sum_y <= {1'b0, rdata};
        adl_pkg::TAP_YU:     sum_y <= sum_y + {1'b0, rdata};
        adl_pkg::TAP_ZL:     sum_z <= {1'b0, rdata};
        adl_pkg::TAP_ZU:     sum_z <= sum_z + {1'b0, rdata};
        default: ;
      endcase
    end
  end

  always_comb begin
    fx = 35'(px >>> 16);
    fy = 35'(py >>> 16);
    fz = 35'(pz >>> 16);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    rd_step <= step;
    if (state == S_DIFF) begin
      dx <= $signed({1'b0, sum_x}) - $signed({1'b0, centre, 1'b0});
      dy <= $signed({1'b0, sum_y}) - $signed({1'b0, centre, 1'b0});
      dz <= $signed({1'b0, sum_z}) - $signed({1'b0, centre, 1'b0});
    end
    if (state == S_MUL) begin
      px <= 51'(dx * $signed({1'b0, coef_long}));
      py <= 51'(dy * $signed({1'b0, coef_trans}));
      pz <= 51'(dz * $signed({1'b0, coef_trans}));
    end
    if (pop && (head.kind == adl_pkg::KIND_BAD)) begin
      result.flux      <= '0;
      result.bad_coord <= 1'b1;
    end else if (state == S_SUM) begin
      result.flux      <= 37'(fx) + 37'(fy) + 37'(fz);
      result.bad_coord <= 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= adl_pkg::TAP_CENTRE;
      rd_live      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_live      <= (state == S_READ);
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              adl_pkg::KIND_QUERY: begin
                step  <= adl_pkg::TAP_CENTRE;
                state <= S_READ;
              end
              adl_pkg::KIND_BAD: begin
                result_valid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (step == adl_pkg::TAP_ZU) begin
            state <= S_DRAIN;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_DRAIN: state <= S_DIFF;
        S_DIFF:  state <= S_MUL;
        S_MUL:   state <= S_SUM;
        S_SUM: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/anisotropic_diffusion_laplacian_3d.sv
// a query's result follows seven reads of the single-port grid memory and the drain,
// difference, multiply and sum states; a bad query's result is registered as it leaves the queue;
// the back takes one query at a time while the two-entry queue buffers new beats; a write or bad
// query leaves it idle; busy rises only while the queue is full; the receiver cannot stall
// reset: synchronous, sizes return to 32, coefficients to 0, queue and result valid cleared;
// the grid store keeps no reset and holds junk until written
`default_nettype none

module anisotropic_diffusion_laplacian_3d #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // command side: a beat is taken when start is high and busy is low
  input  wire                                  start,
  output logic                                 busy,
  input  wire adl_pkg::item_t                  item,
  // result side: one beat per query, shown for a single cycle
  output logic                                 result_valid,
  output adl_pkg::result_t                     result,
  // register writes
  input  wire                                  cfg_we,
  input  wire logic [adl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [adl_pkg::DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [adl_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic [adl_pkg::DATA_W-1:0] coef_long, coef_trans;

  // front to queue to back
  logic             push;
  adl_pkg::entry_t  push_entry;
  adl_pkg::entry_t  head;
  logic             empty;
  logic             full;
  logic             pop;

  // writes beyond the register list fall through and are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= adl_pkg::SIZE_W'(32);
      size_y     <= adl_pkg::SIZE_W'(32);
      size_z     <= adl_pkg::SIZE_W'(32);
      coef_long  <= '0;
      coef_trans <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adl_pkg::REG_SIZE_X:     size_x     <= cfg_data[adl_pkg::SIZE_W-1:0];
        adl_pkg::REG_SIZE_Y:     size_y     <= cfg_data[adl_pkg::SIZE_W-1:0];
        adl_pkg::REG_SIZE_Z:     size_z     <= cfg_data[adl_pkg::SIZE_W-1:0];
        adl_pkg::REG_COEF_LONG:  coef_long  <= cfg_data;
        adl_pkg::REG_COEF_TRANS: coef_trans <= cfg_data;
        default: ;
      endcase
    end
  end

  // only a full queue holds the command side off
  assign busy = full;

  // front: classify each beat, work out the reflected neighbours
  adl_front #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_front (
    .item   (item),
    .start  (start),
    .full   (full),
    .size_x (size_x),
    .size_y (size_y),
    .size_z (size_z),
    .push   (push),
    .entry  (push_entry)
  );

  // short queue decoupling front and back
  adl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // back: grid memory, stencil reads and the scaled sum
  adl_back #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .coef_long    (coef_long),
    .coef_trans   (coef_trans),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import adl_pkg::*;

  // grid geometry as built: 32 cells per axis
  localparam int GRID_DIM = 32;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int MIN_SIZE = 2;
  localparam int TAP_COUNT = 7;
  localparam int REG_COUNT = 5;

  // run control
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 20;   // writes leave no trace
  localparam int END_CYCLES = 30;
  localparam int PHASE_BEATS = 90;
  localparam int CYCLE_LIMIT = 200000;

  // expected flux per query, worked out from a private copy of the grid
  class flux_scoreboard;
    logic [DATA_W-1:0] conc_grid [GRID_CELLS];
    bit                filled [GRID_CELLS];
    int                dim [3];
    logic [DATA_W-1:0] coef_long;
    logic [DATA_W-1:0] coef_trans;
    result_t           flux_due [$];
    int                mismatches;

    function new();
      dim = '{GRID_DIM, GRID_DIM, GRID_DIM};
      coef_long = '0;
      coef_trans = '0;
      mismatches = 0;
    endfunction

    function int clamp_size(logic [SIZE_W-1:0] raw);
      if (raw < MIN_SIZE) return MIN_SIZE;
      if (raw > GRID_DIM) return GRID_DIM;
      return raw;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_SIZE_X:     dim[0] = clamp_size(val[SIZE_W-1:0]);
        REG_SIZE_Y:     dim[1] = clamp_size(val[SIZE_W-1:0]);
        REG_SIZE_Z:     dim[2] = clamp_size(val[SIZE_W-1:0]);
        REG_COEF_LONG:  coef_long = val;
        REG_COEF_TRANS: coef_trans = val;
        default: ;
      endcase
    endfunction

    function int cell_of(int x, int y, int z);
      return x + GRID_DIM * (y + GRID_DIM * z);
    endfunction

    function bit in_range(int x, int y, int z);
      return x < dim[0] && y < dim[1] && z < dim[2];
    endfunction

    // mirror at the faces: the missing neighbour is the one on the other side
    function int lower_nb(int c);
      return (c == 0) ? 1 : c - 1;
    endfunction

    function int upper_nb(int c, int n);
      return (c + 1 >= n) ? c - 1 : c + 1;
    endfunction

    function int tap_cell(int x, int y, int z, logic [2:0] tap);
      int cx, cy, cz;
      cx = x;
      cy = y;
      cz = z;
      case (tap)
        TAP_XL: cx = lower_nb(x);
        TAP_XU: cx = upper_nb(x, dim[0]);
        TAP_YL: cy = lower_nb(y);
        TAP_YU: cy = upper_nb(y, dim[1]);
        TAP_ZL: cz = lower_nb(z);
        TAP_ZU: cz = upper_nb(z, dim[2]);
        default: ;
      endcase
      return cell_of(cx, cy, cz);
    endfunction

    // first stencil cell not yet written, or -1
    function int first_gap(int x, int y, int z);
      int c;
      for (int t = 0; t < TAP_COUNT; t++) begin
        c = tap_cell(x, y, z, 3'(t));
        if (!filled[c]) return c;
      end
      return -1;
    endfunction

    function longint tap_value(int x, int y, int z, logic [2:0] tap);
      return {40'd0, conc_grid[tap_cell(x, y, z, tap)]};
    endfunction

    // product shifted right arithmetically, so negatives round down
    function longint scaled(longint diff, logic [DATA_W-1:0] coef);
      longint k;
      longint p;
      k = coef;
      p = diff * k;
      return p >>> 16;
    endfunction

    function logic signed [FLUX_W-1:0] stencil_flux(int x, int y, int z);
      longint centre, dx, dy, dz, total;
      centre = tap_value(x, y, z, TAP_CENTRE);
      dx = tap_value(x, y, z, TAP_XL) + tap_value(x, y, z, TAP_XU) - 2 * centre;
      dy = tap_value(x, y, z, TAP_YL) + tap_value(x, y, z, TAP_YU) - 2 * centre;
      dz = tap_value(x, y, z, TAP_ZL) + tap_value(x, y, z, TAP_ZU) - 2 * centre;
      total = scaled(dx, coef_long) + scaled(dy, coef_trans) + scaled(dz, coef_trans);
      return total[FLUX_W-1:0];
    endfunction

    function void note_beat(item_t beat);
      result_t due;
      int c;
      if (beat.func == FUNC_WRITE) begin
        c = cell_of(beat.cell_x, beat.cell_y, beat.cell_z);
        conc_grid[c] = beat.conc_value;
        filled[c] = 1'b1;
        return;
      end
      if (!in_range(beat.cell_x, beat.cell_y, beat.cell_z)) begin
        due.flux = '0;
        due.bad_coord = 1'b1;
      end else begin
        due.flux = stencil_flux(beat.cell_x, beat.cell_y, beat.cell_z);
        due.bad_coord = 1'b0;
      end
      flux_due.push_back(due);
    endfunction

    function int pending();
      return flux_due.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_flux(result_t got);
      result_t due;
      if (flux_due.size() == 0) begin
        report_mismatch($sformatf("result with none due: flux %0d bad_coord %0b",
                                  got.flux, got.bad_coord));
        return;
      end
      due = flux_due.pop_front();
      if (got.flux !== due.flux)
        report_mismatch($sformatf("flux %0d, expected %0d", got.flux, due.flux));
      if (got.bad_coord !== due.bad_coord)
        report_mismatch($sformatf("bad_coord %0b, expected %0b",
                                  got.bad_coord, due.bad_coord));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                item = '0;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  flux_scoreboard sb = new();

  int          idle_pct = 0;      // chance in a hundred that the sender idles, rolled again after each idle clock
  int          beats_sent = 0;
  int          last_x = 0;        // recent query, so neighbourhoods get reused
  int          last_y = 0;
  int          last_z = 0;
  int unsigned cycle_count = 0;

  anisotropic_diffusion_laplacian_3d dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every result beat lasts one cycle and is checked at the edge closing it
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sb.check_flux(result);
    end
  end

  // watchdog: a hung handshake or a missing result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // concentrations lean on the extremes, with small values now and then
  function automatic logic [DATA_W-1:0] rand_conc();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = DATA_W'($urandom_range(0, 255));
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 24'h010000;   // exactly one in q8.16
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // raw size register: below two and above the grid both get exercised
  function automatic logic [DATA_W-1:0] rand_size();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 24'd0;
      1: v = 24'd1;
      2: v = 24'd2;
      3: v = 24'd32;
      4: v = DATA_W'($urandom_range(33, 63));
      default: v = DATA_W'($urandom_range(2, 32));
    endcase
    return v;
  endfunction

  // faces, anywhere, or a step from the previous coordinate
  function automatic int pick_coord(int n, int prev);
    int c;
    case ($urandom_range(0, 9))
      0: c = 0;
      1: c = n - 1;
      2, 3, 4: c = $urandom_range(0, n - 1);
      default: c = prev + int'($urandom_range(0, 2)) - 1;
    endcase
    if (c < 0) c = 0;
    if (c > n - 1) c = n - 1;
    return c;
  endfunction

  function automatic item_t make_beat(logic func, int x, int y, int z,
                                      logic [DATA_W-1:0] v);
    item_t b;
    b.func = func;
    b.cell_x = x[COORD_W-1:0];
    b.cell_y = y[COORD_W-1:0];
    b.cell_z = z[COORD_W-1:0];
    b.conc_value = v;
    return b;
  endfunction

  // start stays high from one beat to the next unless the sender idles
  task automatic send_beat(input item_t beat);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= beat;
    do @(posedge clk); while (busy);
    sb.note_beat(beat);
    beats_sent++;
  endtask

  task automatic write_cell(input int x, input int y, input int z,
                            input logic [DATA_W-1:0] v);
    send_beat(make_beat(FUNC_WRITE, x, y, z, v));
  endtask

  // fill any stencil cell still unwritten if the cell is in range, then ask for the flux
  task automatic query_cell(input int x, input int y, input int z);
    int gap;
    if (sb.in_range(x, y, z)) begin
      gap = sb.first_gap(x, y, z);
      while (gap >= 0) begin
        write_cell(gap % GRID_DIM, (gap / GRID_DIM) % GRID_DIM,
                   gap / (GRID_DIM * GRID_DIM), rand_conc());
        gap = sb.first_gap(x, y, z);
      end
    end
    send_beat(make_beat(FUNC_QUERY, x, y, z, rand_conc()));
  endtask

  // hold off until every due result is back, then linger
  task automatic wait_quiet(input int settle);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // register writes only once the block has gone quiet
  task automatic apply_setting(input logic [DATA_W-1:0] sx, sy, sz, cl, ct);
    logic [CFG_IDX_W-1:0] reg_idx [REG_COUNT];
    logic [DATA_W-1:0]    reg_val [REG_COUNT];
    reg_idx = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_COEF_LONG, REG_COEF_TRANS};
    reg_val = '{sx, sy, sz, cl, ct};
    wait_quiet(SETTLE_CYCLES);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data <= reg_val[i];
      @(posedge clk);
      sb.set_reg(reg_idx[i], reg_val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly queries around a wandering spot, some anywhere, writes scattered in, now and then a drain
  task automatic run_phase(input int idle, input int count);
    int first;
    int roll;
    idle_pct = idle;
    first = beats_sent;
    while (beats_sent - first < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        last_x = pick_coord(sb.dim[0], last_x);
        last_y = pick_coord(sb.dim[1], last_y);
        last_z = pick_coord(sb.dim[2], last_z);
        query_cell(last_x, last_y, last_z);
      end else if (roll < 75) begin
        query_cell($urandom_range(0, GRID_DIM - 1), $urandom_range(0, GRID_DIM - 1),
                   $urandom_range(0, GRID_DIM - 1));
      end else if (roll < 97) begin
        // may land outside the size in use: still stored
        write_cell(pick_coord(GRID_DIM, last_x), pick_coord(GRID_DIM, last_y),
                   pick_coord(GRID_DIM, last_z), rand_conc());
      end else begin
        wait_quiet(0);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // full grid, strongest x coefficient against the weakest transverse one
    apply_setting(24'd32, 24'd32, 24'd32, '1, 24'd1);

    // origin corner: lower neighbours mirrored, big negative curvature
    write_cell(0, 0, 0, '1);
    write_cell(1, 0, 0, '0);
    write_cell(0, 1, 0, '0);
    write_cell(0, 0, 1, '1);
    query_cell(0, 0, 0);

    // far corner: upper faces mirrored, positive curvature
    write_cell(31, 31, 31, '0);
    write_cell(30, 31, 31, '1);
    write_cell(31, 30, 31, '1);
    write_cell(31, 31, 30, '1);
    query_cell(31, 31, 31);

    // sender holds off until the block has drained
    wait_quiet(0);
    query_cell(31, 31, 31);

    // smallest grid, unit and full-scale coefficients
    apply_setting(24'd2, 24'd2, 24'd2, 24'h010000, '1);
    query_cell(0, 0, 0);
    query_cell(1, 1, 1);

    // out of the size in use on each axis in turn
    query_cell(31, 0, 0);
    query_cell(0, 31, 0);
    query_cell(0, 0, 2);

    // outside the size in use but inside the grid: kept for later
    write_cell(20, 20, 20, rand_conc());

    // random phases, each under its own setting and idling pattern
    apply_setting(24'd32, 24'd32, 24'd32, rand_coef(), rand_coef());
    run_phase(0, PHASE_BEATS);

    apply_setting(24'd2, 24'd2, 24'd2, '1, '1);
    run_phase(48, PHASE_BEATS);

    // sizes zero and one act as two, junk above the size field is dropped
    apply_setting(24'd0, 24'd1, {18'($urandom), 6'd63}, '0, rand_coef());
    run_phase(18, PHASE_BEATS);

    apply_setting(rand_size(), rand_size(), rand_size(), rand_coef(), rand_coef());
    run_phase(48, PHASE_BEATS);

    apply_setting(24'd32, rand_size(), rand_size(), '1, '0);
    run_phase(0, PHASE_BEATS);

    apply_setting(rand_size(), rand_size(), rand_size(), rand_coef(), rand_coef());
    run_phase(18, PHASE_BEATS);

    // drain, then give a stray result time to show up
    wait_quiet(END_CYCLES);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
